@@ rtl/vlmq_pkg.sv @@
// shared constants, codes and types for the variable-length message queue
// no dependencies
`default_nettype none

package vlmq_pkg;

  // byte ring and descriptor queue geometry
  localparam int POOL_BYTES   = 4096;
  localparam int OFS_W        = 12;
  localparam int LEN_W        = 12;
  localparam int MAX_MESSAGES = 255;
  localparam int SLOT_W       = 8;
  localparam int DESC_DEPTH   = 2 ** SLOT_W;
  localparam int DESC_W       = OFS_W + LEN_W;

  // transfer modes
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DESC  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_SEQ      = 3'd4;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       data_out;
    logic [LEN_W-1:0] head_length;
    logic             last_byte;
    logic             queue_empty;
  } res_t;

  // outcome of placing a new message in the ring
  typedef struct packed {
    logic [2:0]       status;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] new_wofs;
  } place_t;

endpackage

`default_nettype wire

@@ rtl/variable_length_message_queue.sv @@
// top level of the variable-length message queue: byte ring, descriptor memory, sequencer
// depends on vlmq_pkg and vlmq_place
`default_nettype none

// channel   direction  ports                                       transfer when
// in_       input      in_mode, in_msg_length, in_data_in          in_valid & in_ready
// out_      output     out_status, out_data_out, out_head_length,  out_valid & out_ready
//                      out_last_byte, out_queue_empty
//
// begin, write-byte, clear and a read of an empty queue form their result at once.
// a read of a held message steps through descriptor read, byte read and result, with an extra
// descriptor read of the new release offset when it releases a message that has a successor.
// the descriptor and byte memories have registered reads, which set these steps.
// reset clears all control state but the payload registers; the memories need no clearing pass.
// results go into a two-entry output queue, so a new item is taken while a result waits.

module variable_length_message_queue
  import vlmq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_mode,
  input  wire logic [LEN_W-1:0] in_msg_length,
  input  wire logic [7:0]       in_data_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            out_status,
  output logic [7:0]            out_data_out,
  output logic [LEN_W-1:0]      out_head_length,
  output logic                  out_last_byte,
  output logic                  out_queue_empty
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DESC = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;
  localparam logic [1:0] S_REL  = 2'd3;

  // storage
  logic [7:0]        byte_mem [POOL_BYTES];
  logic [DESC_W-1:0] desc_mem [DESC_DEPTH];

  // control state
  logic [1:0]        state_r,      state_nxt;
  logic [SLOT_W-1:0] head_r,       head_nxt;
  logic [SLOT_W-1:0] tail_r,       tail_nxt;
  logic [SLOT_W-1:0] queued_r,     queued_nxt;
  logic [OFS_W-1:0]  wofs_r,       wofs_nxt;
  logic [OFS_W-1:0]  rel_r,        rel_nxt;
  logic              open_r,       open_nxt;
  logic [LEN_W-1:0]  remain_r,     remain_nxt;
  logic [LEN_W-1:0]  cursor_r,     cursor_nxt;
  logic [OFS_W-1:0]  wr_ptr_r,     wr_ptr_nxt;
  logic [OFS_W-1:0]  open_start_r, open_start_nxt;
  logic [LEN_W-1:0]  cur_len_r,    cur_len_nxt;
  logic              cur_last_r,   cur_last_nxt;

  // output queue
  logic v0_r, v0_nxt, v1_r, v1_nxt;
  res_t o0_r, o0_nxt, o1_r, o1_nxt;

  // memory ports
  logic              desc_we, desc_re;
  logic [SLOT_W-1:0] desc_wa, desc_ra;
  logic [DESC_W-1:0] desc_wd, desc_q_r;
  logic              byte_we, byte_re;
  logic [OFS_W-1:0]  byte_wa, byte_ra;
  logic [7:0]        byte_wd, byte_q_r;

  logic              in_fire, pop, push;
  res_t              res;
  place_t            place;
  logic [OFS_W-1:0]  d_start;
  logic [LEN_W-1:0]  d_len;
  logic              is_last;

  vlmq_place u_place (
    .wofs    (wofs_r),
    .rel     (rel_r),
    .len     (in_msg_length),
    .queued  (queued_r),
    .open_wr (open_r),
    .place   (place)
  );

  // item taken only in idle and while the second output entry is free
  assign in_ready = (state_r == S_IDLE) && !v1_r;
  assign in_fire  = in_valid && in_ready;
  assign pop      = v0_r && out_ready;

  assign d_start = desc_q_r[DESC_W-1:LEN_W];
  assign d_len   = desc_q_r[LEN_W-1:0];
  assign is_last = ({1'b0, cursor_r} + (LEN_W+1)'(1)) >= {1'b0, d_len};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    queued_nxt     = queued_r;
    wofs_nxt       = wofs_r;
    rel_nxt        = rel_r;
    open_nxt       = open_r;
    remain_nxt     = remain_r;
    cursor_nxt     = cursor_r;
    wr_ptr_nxt     = wr_ptr_r;
    open_start_nxt = open_start_r;
    cur_len_nxt    = cur_len_r;
    cur_last_nxt   = cur_last_r;
    push           = 1'b0;
    res            = '0;
    desc_we        = 1'b0;
    desc_wa        = tail_r;
    desc_wd        = {place.start, in_msg_length};
    desc_re        = 1'b0;
    desc_ra        = head_r;
    byte_we        = 1'b0;
    byte_wa        = wr_ptr_r;
    byte_wd        = in_data_in;
    byte_re        = 1'b0;
    byte_ra        = d_start + cursor_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_BEGIN: begin
              push            = 1'b1;
              res.status      = place.status;
              res.queue_empty = (queued_r == '0);
              if (place.status == ST_OK) begin
                wofs_nxt       = place.new_wofs;
                if (queued_r == '0) begin
                  rel_nxt = place.start;
                end
                desc_we        = 1'b1;
                open_nxt       = 1'b1;
                remain_nxt     = in_msg_length;
                wr_ptr_nxt     = place.start;
                open_start_nxt = place.start;
              end
            end
            MODE_WRITE: begin
              push            = 1'b1;
              res.queue_empty = (queued_r == '0);
              if (!open_r) begin
                res.status = ST_SEQ;
              end else begin
                byte_we    = 1'b1;
                wr_ptr_nxt = wr_ptr_r + OFS_W'(1);
                remain_nxt = remain_r - LEN_W'(1);
                // last byte commits the message
                if (remain_r == LEN_W'(1)) begin
                  open_nxt        = 1'b0;
                  tail_nxt        = tail_r + SLOT_W'(1);
                  queued_nxt      = queued_r + SLOT_W'(1);
                  res.queue_empty = 1'b0;
                end
              end
            end
            MODE_READ: begin
              if (queued_r == '0) begin
                push            = 1'b1;
                res.status      = ST_EMPTY;
                res.queue_empty = 1'b1;
              end else begin
                desc_re   = 1'b1;
                state_nxt = S_DESC;
              end
            end
            default: begin
              // clear: drop committed messages and any open write
              push            = 1'b1;
              res.queue_empty = 1'b1;
              head_nxt        = tail_r;
              queued_nxt      = '0;
              open_nxt        = 1'b0;
              remain_nxt      = '0;
              cursor_nxt      = '0;
              rel_nxt         = wofs_r;
            end
          endcase
        end
      end
      S_DESC: begin
        // head descriptor is here: fetch the byte under the read cursor
        byte_re      = 1'b1;
        cur_len_nxt  = d_len;
        cur_last_nxt = is_last;
        cursor_nxt   = is_last ? '0 : cursor_r + LEN_W'(1);
        state_nxt    = S_BYTE;
      end
      S_BYTE: begin
        push            = 1'b1;
        res.data_out    = byte_q_r;
        res.head_length = cur_len_r;
        res.last_byte   = cur_last_r;
        res.queue_empty = 1'b0;
        state_nxt       = S_IDLE;
        if (cur_last_r) begin
          head_nxt        = head_r + SLOT_W'(1);
          queued_nxt      = queued_r - SLOT_W'(1);
          res.queue_empty = (queued_r == SLOT_W'(1));
          if (queued_r > SLOT_W'(1)) begin
            // release offset follows the start of the next committed message
            desc_re   = 1'b1;
            desc_ra   = head_r + SLOT_W'(1);
            state_nxt = S_REL;
          end else begin
            rel_nxt = open_r ? open_start_r : wofs_r;
          end
        end
      end
      S_REL: begin
        rel_nxt   = d_start;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output queue: a push always finds room, as items wait for the second entry to drain
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    o0_nxt = o0_r;
    o1_nxt = o1_r;
    if (pop) begin
      if (v1_r) begin
        o0_nxt = o1_r;
        v1_nxt = push;
        o1_nxt = res;
      end else begin
        v0_nxt = push;
        o0_nxt = res;
      end
    end else if (push) begin
      if (v0_r) begin
        v1_nxt = 1'b1;
        o1_nxt = res;
      end else begin
        v0_nxt = 1'b1;
        o0_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      queued_r   <= '0;
      wofs_r     <= '0;
      rel_r      <= '0;
      open_r     <= 1'b0;
      remain_r   <= '0;
      cursor_r   <= '0;
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      queued_r   <= queued_nxt;
      wofs_r     <= wofs_nxt;
      rel_r      <= rel_nxt;
      open_r     <= open_nxt;
      remain_r   <= remain_nxt;
      cursor_r   <= cursor_nxt;
      v0_r       <= v0_nxt;
      v1_r       <= v1_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wr_ptr_r     <= wr_ptr_nxt;
    open_start_r <= open_start_nxt;
    cur_len_r    <= cur_len_nxt;
    cur_last_r   <= cur_last_nxt;
    o0_r         <= o0_nxt;
    o1_r         <= o1_nxt;
  end

  // descriptor memory
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= desc_wd;
    end
    if (desc_re) begin
      desc_q_r <= desc_mem[desc_ra];
    end
  end

  // byte ring
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_wa] <= byte_wd;
    end
    if (byte_re) begin
      byte_q_r <= byte_mem[byte_ra];
    end
  end

  assign out_valid       = v0_r;
  assign out_status      = o0_r.status;
  assign out_data_out    = o0_r.data_out;
  assign out_head_length = o0_r.head_length;
  assign out_last_byte   = o0_r.last_byte;
  assign out_queue_empty = o0_r.queue_empty;

endmodule

`default_nettype wire

@@ rtl/vlmq_place.sv @@
// placement check for a new message in the byte ring
// depends on vlmq_pkg
`default_nettype none

module vlmq_place
  import vlmq_pkg::*;
(
  input  wire logic [OFS_W-1:0]  wofs,
  input  wire logic [OFS_W-1:0]  rel,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic [SLOT_W-1:0] queued,
  input  wire logic              open_wr,
  output place_t                 place
);

  logic [OFS_W:0] sum;
  logic           fit_here;

  assign sum = {1'b0, wofs} + {1'b0, len};

  assign fit_here = ((wofs >= rel) && (sum < (OFS_W+1)'(POOL_BYTES))) ||
                    ((wofs < rel) && (sum < {1'b0, rel}));

  always_comb begin
    place.status   = ST_OK;
    place.start    = wofs;
    place.new_wofs = sum[OFS_W-1:0];
    if (open_wr || (len == '0)) begin
      place.status = ST_SEQ;
    end else if (queued >= SLOT_W'(MAX_MESSAGES)) begin
      place.status = ST_NO_DESC;
    end else if (fit_here) begin
      place.start    = wofs;
      place.new_wofs = sum[OFS_W-1:0];
    end else if (len < rel) begin
      place.start    = '0;
      place.new_wofs = len;
    end else begin
      place.status = ST_NO_SPACE;
    end
  end

endmodule

`default_nettype wire

@@ dv/vlmq_checker.sv @@
// result checker for the variable-length message queue: tracks the ring and descriptor state,
// predicts one result per input transfer and compares it with each output transfer
// depends on vlmq_pkg
`timescale 1ns / 100ps

module vlmq_checker
  import vlmq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [1:0]       in_mode,
  input  wire logic [LEN_W-1:0] in_msg_length,
  input  wire logic [7:0]       in_data_in,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic [2:0]       out_status,
  input  wire logic [7:0]       out_data_out,
  input  wire logic [LEN_W-1:0] out_head_length,
  input  wire logic             out_last_byte,
  input  wire logic             out_queue_empty,
  output int                    mismatches,
  output int                    pending,
  output int                    results_checked,
  output int                    bytes_read,
  output int                    released,
  output int                    rejected
);

  // shadow of the ring, the descriptors and the offsets
  logic [7:0] ring_bytes [POOL_BYTES];
  int         slot_start [DESC_DEPTH];
  int         slot_len   [DESC_DEPTH];
  int         rd_slot, wr_slot, committed;
  int         wr_ofs, free_ofs, wr_left, rd_pos;
  bit         wr_busy;

  res_t       awaited_results [$];

  function automatic res_t queue_step_result(input logic [1:0] mode,
                                             input logic [LEN_W-1:0] len,
                                             input logic [7:0] din);
    res_t r;
    int   start, pos;
    bit   placed;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_BEGIN: begin
        if (wr_busy || len == 0) begin
          r.status = ST_SEQ;
        end else if (committed >= MAX_MESSAGES) begin
          r.status = ST_NO_DESC;
        end else begin
          placed = 1'b1;
          // strict less-than against both the ring end and the release offset
          if ((wr_ofs >= free_ofs && wr_ofs + int'(len) < POOL_BYTES) ||
              (wr_ofs < free_ofs && wr_ofs + int'(len) < free_ofs)) begin
            start = wr_ofs;
          end else if (int'(len) < free_ofs) begin
            start = 0;
          end else begin
            placed = 1'b0;
            start  = 0;
          end
          if (!placed) begin
            r.status = ST_NO_SPACE;
          end else begin
            wr_ofs = start + int'(len);
            if (committed == 0) free_ofs = start;
            slot_start[wr_slot] = start;
            slot_len[wr_slot]   = int'(len);
            wr_busy = 1'b1;
            wr_left = int'(len);
          end
        end
      end
      MODE_WRITE: begin
        if (!wr_busy) begin
          r.status = ST_SEQ;
        end else begin
          pos = (slot_start[wr_slot] + slot_len[wr_slot] - wr_left) % POOL_BYTES;
          ring_bytes[pos] = din;
          wr_left--;
          if (wr_left == 0) begin
            wr_busy   = 1'b0;
            wr_slot   = (wr_slot + 1) % DESC_DEPTH;
            committed++;
          end
        end
      end
      MODE_READ: begin
        if (committed == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = (slot_start[rd_slot] + rd_pos) % POOL_BYTES;
          r.data_out    = ring_bytes[pos];
          r.head_length = slot_len[rd_slot][LEN_W-1:0];
          rd_pos++;
          if (rd_pos >= slot_len[rd_slot]) begin
            r.last_byte = 1'b1;
            rd_pos      = 0;
            rd_slot     = (rd_slot + 1) % DESC_DEPTH;
            committed--;
            // release point moves to the oldest message still held, open or not
            if (committed > 0)  free_ofs = slot_start[rd_slot];
            else if (wr_busy)   free_ofs = slot_start[wr_slot];
            else                free_ofs = wr_ofs;
          end
        end
      end
      default: begin
        rd_slot   = wr_slot;
        committed = 0;
        wr_busy   = 1'b0;
        wr_left   = 0;
        rd_pos    = 0;
        free_ofs  = wr_ofs;
      end
    endcase
    r.queue_empty = (committed == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      rd_slot   = 0;
      wr_slot   = 0;
      committed = 0;
      wr_ofs    = 0;
      free_ofs  = 0;
      wr_busy   = 1'b0;
      wr_left   = 0;
      rd_pos    = 0;
      awaited_results.delete();
      pending         <= 0;
      mismatches      <= 0;
      results_checked <= 0;
      bytes_read      <= 0;
      released        <= 0;
      rejected        <= 0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(queue_step_result(in_mode, in_msg_length, in_data_in));
      if (out_valid && out_ready) begin
        got = '{out_status, out_data_out, out_head_length, out_last_byte, out_queue_empty};
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing awaited: status %0d data %02h len %0d",
                     $realtime, got.status, got.data_out, got.head_length);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display({"%0t: mismatch: expected status %0d data %02h len %0d last %0d ",
                        "empty %0d, got status %0d data %02h len %0d last %0d empty %0d"},
                       $realtime, want.status, want.data_out, want.head_length,
                       want.last_byte, want.queue_empty, got.status, got.data_out,
                       got.head_length, got.last_byte, got.queue_empty);
            mismatches <= mismatches + 1;
          end
          results_checked <= results_checked + 1;
          if (want.status == ST_OK && want.head_length != 0) bytes_read <= bytes_read + 1;
          if (want.last_byte) released <= released + 1;
          if (want.status != ST_OK) rejected <= rejected + 1;
        end
      end
      pending <= awaited_results.size();
    end
  end

endmodule

@@ dv/tb_variable_length_message_queue.sv @@
// testbench top for the variable-length message queue: clock, reset, transfer stimulus,
// receiver back-pressure, watchdog and verdict
// depends on vlmq_pkg, vlmq_checker and the variable_length_message_queue rtl
`timescale 1ns / 100ps

module tb_variable_length_message_queue;
  import vlmq_pkg::*;

  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off to fill the block
  localparam int QUIET_LIMIT  = 2000; // cycles with no transfer before giving up
  localparam int ITEMS_TARGET = 960;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [1:0]       in_mode       = MODE_READ;
  logic [LEN_W-1:0] in_msg_length = '0;
  logic [7:0]       in_data_in    = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [2:0]       out_status;
  logic [7:0]       out_data_out;
  logic [LEN_W-1:0] out_head_length;
  logic             out_last_byte;
  logic             out_queue_empty;

  // idle percentages per side, changed between phases
  int send_idle_pct = 35;
  int recv_idle_pct = 51;

  int items_sent   = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  int mismatches, pending, results_checked, bytes_read, released, rejected;

  // 12 ns period, low phase first so time zero is not an edge
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  variable_length_message_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_msg_length   (in_msg_length),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_head_length (out_head_length),
    .out_last_byte   (out_last_byte),
    .out_queue_empty (out_queue_empty)
  );

  vlmq_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_msg_length   (in_msg_length),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_head_length (out_head_length),
    .out_last_byte   (out_last_byte),
    .out_queue_empty (out_queue_empty),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .bytes_read      (bytes_read),
    .released        (released),
    .rejected        (rejected)
  );

  // receiver: random stalls, plus a counted hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_reqs;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("variable_length_message_queue verification failed");
        $finish;
      end
    end
  end

  // one input transfer; valid is only dropped for idle gaps, never between back-to-back items
  task automatic send(input logic [1:0] mode, input logic [LEN_W-1:0] len,
                      input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_msg_length <= len;
    in_data_in    <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // well-formed message: begin then exactly len data bytes, unused fields randomised
  task automatic put_message(input int len);
    send(MODE_BEGIN, len[LEN_W-1:0], 8'($urandom_range(255)));
    repeat (len) send(MODE_WRITE, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
  endtask

  task automatic read_bytes(input int n);
    repeat (n) send(MODE_READ, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
  endtask

  // mostly whole messages and read bursts, with ring skips, cut-short writes and noise
  task automatic random_traffic(input int stop_at);
    int pick, len;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        pick = $urandom_range(99);
        if (pick < 80)      len = $urandom_range(8, 1);
        else if (pick < 97) len = $urandom_range(40, 9);
        else                len = $urandom_range(120, 41);
        put_message(len);
      end else if (pick < 65) begin
        read_bytes($urandom_range(12, 1));
      end else if (pick < 72) begin
        // begin of any length then clear: moves the write offset round the ring cheaply
        send(MODE_BEGIN, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
        send(MODE_CLEAR, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
      end else if (pick < 80) begin
        // write left open part way, later begins see a sequence error
        len = $urandom_range(10, 2);
        send(MODE_BEGIN, len[LEN_W-1:0], 8'($urandom_range(255)));
        repeat ($urandom_range(len - 1))
          send(MODE_WRITE, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
      end else begin
        send(2'($urandom_range(3)), LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty read, stray byte, zero length, longest message,
    // begin over an open write, no ring space, exact ring-end wrap, read-back
    send(MODE_READ,  12'd0,    8'h00);  // queue empty
    send(MODE_WRITE, 12'd0,    8'hFF);  // no write open, byte dropped
    send(MODE_BEGIN, 12'd0,    8'h00);  // zero length rejected
    send(MODE_BEGIN, 12'd4095, 8'hFF);  // longest message fits from offset 0
    send(MODE_BEGIN, 12'd3,    8'h00);  // begin while a write is open
    send(MODE_CLEAR, 12'd4095, 8'hFF);  // drops the open write, release at 4095
    send(MODE_BEGIN, 12'd4095, 8'h00);  // neither fits above nor wraps
    send(MODE_BEGIN, 12'd1,    8'h00);  // end of message would hit ring end, wraps to 0
    send(MODE_WRITE, 12'd0,    8'h00);
    send(MODE_BEGIN, 12'd2,    8'h00);
    send(MODE_WRITE, 12'd0,    8'hFF);
    send(MODE_WRITE, 12'd0,    8'hA5);
    read_bytes(4);                      // three bytes over two messages, then empty
    send(MODE_CLEAR, 12'd0,    8'h00);

    random_traffic(180);

    // second phase: sender idles more than receiver
    send_idle_pct = 51;
    recv_idle_pct = 35;
    random_traffic(360);

    // last phase: no idling; receiver holds off while the descriptor queue is filled
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send(MODE_CLEAR, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
    hold_reqs++;
    repeat (MAX_MESSAGES) put_message(1);
    send(MODE_BEGIN, 12'd1, 8'($urandom_range(255)));  // no free descriptor
    send(MODE_WRITE, LEN_W'($urandom_range(4095)), 8'($urandom_range(255)));
    read_bytes(30);
    random_traffic(ITEMS_TARGET);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d input transfers over three idling phases, full descriptor queue",
             items_sent);
    $display("checked %0d results: %0d bytes read, %0d messages released, %0d rejected",
             results_checked, bytes_read, released, rejected);
    if (mismatches == 0 && pending == 0) begin
      $display("variable_length_message_queue verification clean");
    end else begin
      $display("variable_length_message_queue verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vlmq_pkg.sv
rtl/vlmq_place.sv
rtl/variable_length_message_queue.sv
dv/vlmq_checker.sv
dv/tb_variable_length_message_queue.sv
